FILE: design/siq_pkg.sv
// ----------------------------------------------------------------------------
// siq_pkg: shared types and constants for the sorted insertion queue
// Opcodes, result status codes, field widths and the control bundle that the
// queue front end broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package siq_pkg;

    // fixed field widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

    // input opcodes
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-beat command broadcast to all cells
    typedef struct packed {
        logic push;    // push that will be stored (queue not full)
        logic pop;     // pop that will remove the front (queue not empty)
        logic sorted;  // sorted insertion instead of append
    } t_cell_ctrl;

endpackage

FILE: design/siq_cell.sv
// ----------------------------------------------------------------------------
// siq_cell: one storage slot of the shift-register queue
// Holds one value. On a push it keeps its value, takes the new value, or takes
// its left neighbor's value; on a pop it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module siq_cell (
    input  logic                                 i_clk,
    input  siq_pkg::t_cell_ctrl                  i_ctrl,
    input  logic                                 i_occupied,
    input  logic signed [siq_pkg::VALUE_W-1:0]   i_value,
    input  logic signed [siq_pkg::VALUE_W-1:0]   i_left_value,
    input  logic signed [siq_pkg::VALUE_W-1:0]   i_right_value,
    input  logic                                 i_left_shift,
    output logic                                 o_shift,
    output logic signed [siq_pkg::VALUE_W-1:0]   o_value
);

    logic signed [siq_pkg::VALUE_W-1:0] r_value;
    logic                               w_greater;
    logic                               w_place;

    // insertion point: first free slot, or in sorted mode first stored entry
    // strictly greater than the new value
    assign w_greater = i_ctrl.sorted && i_occupied && (r_value > i_value);
    assign w_place   = !i_occupied || w_greater;

    // every cell at or past the insertion point moves one place back
    assign o_shift = i_left_shift || w_place;
    assign o_value = r_value;

    // slot update
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            if (i_left_shift) begin
                r_value <= i_left_value;
            end else if (w_place) begin
                r_value <= i_value;
            end
        end else if (i_ctrl.pop) begin
            r_value <= i_right_value;
        end
    end

endmodule

FILE: design/sorted_insertion_queue_core.sv
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one push or pop per cycle; the whole cell row updates in the
// accepting cycle, and a waiting result blocks the input until the cycle in
// which it is taken. Reset (synchronous, active low) empties the queue, clears
// the mode register to first-in first-out and drops the output beat; stored
// values are not cleared, the fill count alone marks which slots hold data.
// ----------------------------------------------------------------------------
// sorted_insertion_queue_core: bounded signed queue, FIFO or sorted insertion
// A row of DEPTH cells stores the entries front first; the front end turns
// each beat into a broadcast push/pop command and tracks the fill count.
// ----------------------------------------------------------------------------
module sorted_insertion_queue_core #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_opcode,
    input  logic signed [siq_pkg::VALUE_W-1:0]   i_value,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [siq_pkg::VALUE_W-1:0]   o_popped_value,
    output logic [1:0]                           o_status,
    output logic [siq_pkg::COUNT_W-1:0]          o_entry_count
);

    localparam logic [siq_pkg::COUNT_W-1:0] FULL_CNT = siq_pkg::COUNT_W'(DEPTH);

    logic                                r_sorted_mode;
    logic [siq_pkg::COUNT_W-1:0]         r_count;
    logic [siq_pkg::COUNT_W-1:0]         n_count;
    logic                                r_out_valid;
    logic signed [siq_pkg::VALUE_W-1:0]  r_popped;
    logic signed [siq_pkg::VALUE_W-1:0]  n_popped;
    siq_pkg::t_status                    r_status;
    siq_pkg::t_status                    n_status;
    logic [siq_pkg::COUNT_W-1:0]         r_out_count;

    logic                                w_accept;
    logic                                w_full;
    logic                                w_empty;
    siq_pkg::t_cell_ctrl                 w_ctrl;

    logic signed [siq_pkg::VALUE_W-1:0]  w_val   [DEPTH];
    logic                                w_shift [DEPTH];

    // handshake: output register frees up when taken or empty
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == FULL_CNT);
    assign w_empty    = (r_count == '0);

    // command broadcast to the cell row
    always_comb begin
        w_ctrl.push   = w_accept && (i_opcode == siq_pkg::OP_PUSH) && !w_full;
        w_ctrl.pop    = w_accept && (i_opcode == siq_pkg::OP_POP) && !w_empty;
        w_ctrl.sorted = r_sorted_mode;
    end

    // result and next fill count
    always_comb begin
        n_count  = r_count;
        n_popped = '0;
        n_status = siq_pkg::ST_OK;
        if (i_opcode == siq_pkg::OP_PUSH) begin
            if (w_full) begin
                n_status = siq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = siq_pkg::ST_EMPTY;
            end else begin
                n_popped = w_val[0];
                n_count  = r_count - 1'b1;
            end
        end
    end

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [siq_pkg::VALUE_W-1:0] w_left;
        logic signed [siq_pkg::VALUE_W-1:0] w_right;
        logic                               w_left_shift;

        if (g == 0) begin : g_front
            assign w_left       = i_value;
            assign w_left_shift = 1'b0;
        end else begin : g_mid
            assign w_left       = w_val[g-1];
            assign w_left_shift = w_shift[g-1];
        end

        if (g == DEPTH - 1) begin : g_back
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_val[g+1];
        end

        siq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occupied    (r_count > siq_pkg::COUNT_W'(g)),
            .i_value       (i_value),
            .i_left_value  (w_left),
            .i_right_value (w_right),
            .i_left_shift  (w_left_shift),
            .o_shift       (w_shift[g]),
            .o_value       (w_val[g])
        );
    end

    // mode register and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sorted_mode <= 1'b0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sorted_mode <= i_cfg_data;
            end
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped    <= n_popped;
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_entry_count  = r_out_count;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count exceeds depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> r_count == $past(r_count) + 1'b1)
        else $error("stored push did not grow the queue");

    a_pop_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |=> o_popped_value == $past(w_val[0]) && r_status == siq_pkg::ST_OK)
        else $error("pop did not return the front entry");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_opcode == siq_pkg::OP_PUSH && w_full
        |=> r_status == siq_pkg::ST_FULL && r_count == FULL_CNT)
        else $error("push to full queue not refused");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.push && w_ctrl.pop))
        else $error("push and pop broadcast together");

endmodule
